>>> rtl/vna_pkg.sv
// shared types and constants for the vertex normal accumulator
`timescale 1ns / 1ps
package vna_pkg;

    localparam int MaxVertices = 1024;
    localparam int IdxW        = 10;
    localparam int CoordW      = 16;
    localparam int SumW        = 20;
    localparam int CrossW      = 2 * (CoordW + 1) + 1;
    localparam int MagW        = 30;
    localparam int SqW         = 2 * MagW + 2;
    localparam int RootW       = SqW / 2;
    localparam int QW          = 16;

    localparam logic [1:0] OpLoad = 2'd0;
    localparam logic [1:0] OpTri  = 2'd1;
    localparam logic [1:0] OpRead = 2'd2;
    localparam logic [1:0] OpRsvd = 2'd3;

    typedef struct packed {
        logic [1:0]               op;
        logic [IdxW-1:0]          index_a;
        logic [IdxW-1:0]          index_b;
        logic [IdxW-1:0]          index_c;
        logic signed [CoordW-1:0] coord_x;
        logic signed [CoordW-1:0] coord_y;
        logic signed [CoordW-1:0] coord_z;
    } t_in_beat;

    typedef struct packed {
        logic [IdxW-1:0]      vertex_index;
        logic signed [QW-1:0] normal_x;
        logic signed [QW-1:0] normal_y;
        logic signed [QW-1:0] normal_z;
    } t_out_beat;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
        logic zero;
    } t_unit_stat;

endpackage

>>> rtl/vna_unit.sv
// shared normalize unit: range reduce, square root, three divisions
`timescale 1ns / 1ps
module vna_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic signed [vna_pkg::CrossW-1:0]       i_vx,
    input  logic signed [vna_pkg::CrossW-1:0]       i_vy,
    input  logic signed [vna_pkg::CrossW-1:0]       i_vz,
    output vna_pkg::t_unit_stat                     o_stat,
    output logic signed [vna_pkg::SumW-1:0]         o_nx,
    output logic signed [vna_pkg::SumW-1:0]         o_ny,
    output logic signed [vna_pkg::SumW-1:0]         o_nz
);
    localparam int CW = vna_pkg::CrossW;
    localparam int MW = vna_pkg::MagW;
    localparam int SW = vna_pkg::SqW;
    localparam int RW = vna_pkg::RootW;
    localparam int OW = vna_pkg::SumW;
    localparam int NW = MW + 15;

    typedef enum logic [2:0] {
        S_IDLE, S_SHIFT, S_SQ, S_ROOT, S_DIVSET, S_DIV, S_NEXT, S_DONE
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_m [3];
    logic [2:0]          r_neg;
    logic [1:0]          r_k;
    logic [SW-1:0]       r_acc;
    logic [SW-1:0]       r_x;
    logic [SW-1:0]       r_r;
    logic [5:0]          r_cnt;
    logic [NW-1:0]       r_num;
    logic [NW-1:0]       r_rem;
    logic [NW-1:0]       r_q;
    logic signed [OW-1:0] r_n [3];

    logic [CW-1:0]       w_m;
    logic [2*MW-1:0]     w_sq;
    logic [SW-1:0]       w_bit;
    logic [SW-1:0]       w_trial;
    logic [NW:0]         w_rem2;
    logic [NW-1:0]       w_len;

    assign w_m     = r_m[r_k];
    assign w_sq    = w_m[MW-1:0] * w_m[MW-1:0];
    assign w_bit   = {{(SW-1){1'b0}}, 1'b1} << {r_cnt, 1'b0};
    assign w_trial = r_r + w_bit;
    assign w_len   = r_r[NW-1:0];
    assign w_rem2  = {r_rem, r_num[NW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_neg   <= {i_vz[CW-1], i_vy[CW-1], i_vx[CW-1]};
                        r_m[0]  <= i_vx[CW-1] ? CW'(-i_vx) : CW'(i_vx);
                        r_m[1]  <= i_vy[CW-1] ? CW'(-i_vy) : CW'(i_vy);
                        r_m[2]  <= i_vz[CW-1] ? CW'(-i_vz) : CW'(i_vz);
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if ((r_m[0] >> MW) != '0 || (r_m[1] >> MW) != '0
                            || (r_m[2] >> MW) != '0) begin
                        r_m[0] <= r_m[0] >> 1;
                        r_m[1] <= r_m[1] >> 1;
                        r_m[2] <= r_m[2] >> 1;
                    end else begin
                        r_k     <= 2'd0;
                        r_acc   <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_acc <= r_acc + SW'(w_sq);
                    if (r_k == 2'd2) begin
                        r_cnt   <= 6'(RW - 1);
                        r_r     <= '0;
                        r_state <= S_ROOT;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                    if (r_k == 2'd2) r_x <= r_acc + SW'(w_sq);
                end
                S_ROOT: begin
                    if (r_x >= w_trial) begin
                        r_x <= r_x - w_trial;
                        r_r <= (r_r >> 1) + w_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    if (r_cnt == '0) begin
                        r_k     <= 2'd0;
                        r_state <= S_DIVSET;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_DIVSET: begin
                    if (r_r == '0) begin
                        r_n[0]  <= '0;
                        r_n[1]  <= '0;
                        r_n[2]  <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_num   <= ({{(NW-MW){1'b0}}, w_m[MW-1:0]} << 14)
                                   + (w_len >> 1);
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_cnt   <= 6'(NW - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_num <= r_num << 1;
                    if (w_rem2 >= {1'b0, w_len}) begin
                        r_rem <= NW'(w_rem2 - {1'b0, w_len});
                        r_q   <= {r_q[NW-2:0], 1'b1};
                    end else begin
                        r_rem <= w_rem2[NW-1:0];
                        r_q   <= {r_q[NW-2:0], 1'b0};
                    end
                    if (r_cnt == '0) r_state <= S_NEXT;
                    else r_cnt <= r_cnt - 6'd1;
                end
                S_NEXT: begin
                    r_n[r_k] <= r_neg[r_k] ? -OW'(r_q) : OW'(r_q);
                    if (r_k == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_DIVSET;
                    end
                end
                S_DONE: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.start = i_start && (r_state == S_IDLE);
    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.done  = (r_state == S_DONE);
    assign o_stat.zero  = (r_r == '0);
    assign o_nx = r_n[0];
    assign o_ny = r_n[1];
    assign o_nz = r_n[2];

endmodule

>>> rtl/vertex_normal_accumulator_core.sv
// top level: vertex and sum memories, op sequencer, shared normalize unit
`timescale 1ns / 1ps
// One beat is handled at a time. A load is written at the accepting edge and
// the block is ready again on the next cycle. A triangle reads its three
// corners and forms the cross product, runs the shared normalize unit (start,
// range shift, 3 squares, a 31-step square root, three divide passes of 45
// steps each; a zero length skips the divides), then updates its three sums.
// A read does one sum read and one normalize pass; its result waits in an
// output register, so the next beat is taken while it is held, and a second
// read stalls in its last state until the first result is taken. The memories
// are accessed one entry at a time, which with the serial root and divider
// sets the beat length. No clearing pass after reset.
module vertex_normal_accumulator_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  vna_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output vna_pkg::t_out_beat o_data
);
    localparam int IW = vna_pkg::IdxW;
    localparam int CWd = vna_pkg::CoordW;
    localparam int XW = vna_pkg::CrossW;
    localparam int SW = vna_pkg::SumW;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_RDW, S_MUL, S_CROSS, S_START, S_WAIT, S_UPRD,
        S_UPWR, S_OUT
    } t_state;

    logic [3*CWd-1:0] r_vmem [vna_pkg::MaxVertices];
    logic [3*SW-1:0]  r_smem [vna_pkg::MaxVertices];

    t_state             r_state;
    vna_pkg::t_in_beat  r_in;
    logic [1:0]         r_k;
    logic [3*CWd-1:0]   r_vrd;
    logic [3*SW-1:0]    r_srd;
    logic signed [CWd:0] r_e1 [3];
    logic signed [CWd:0] r_e2 [3];
    logic signed [CWd-1:0] r_v0 [3];
    logic signed [XW-1:0] r_p [6];
    logic signed [XW-1:0] r_c [3];
    logic               r_start;
    logic               r_vld;
    vna_pkg::t_out_beat r_res;
    vna_pkg::t_out_beat r_out;

    vna_pkg::t_unit_stat w_stat;
    logic signed [SW-1:0] w_n [3];
    logic [IW-1:0]        w_vaddr;
    logic [IW-1:0]        w_uidx;
    logic signed [CWd-1:0] w_c [3];
    logic [3*SW-1:0]      w_sum;

    assign w_vaddr = (r_k == 2'd0) ? r_in.index_a
                   : (r_k == 2'd1) ? r_in.index_b : r_in.index_c;
    assign w_uidx  = w_vaddr;
    assign w_c[0]  = r_vrd[3*CWd-1:2*CWd];
    assign w_c[1]  = r_vrd[2*CWd-1:CWd];
    assign w_c[2]  = r_vrd[CWd-1:0];

    vna_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_vx    (r_c[0]),
        .i_vy    (r_c[1]),
        .i_vz    (r_c[2]),
        .o_stat  (w_stat),
        .o_nx    (w_n[0]),
        .o_ny    (w_n[1]),
        .o_nz    (w_n[2])
    );

    function automatic logic [SW-1:0] sat_add(logic [SW-1:0] a,
                                              logic signed [SW-1:0] b);
        logic signed [SW:0] s;
        s = $signed({a[SW-1], a}) + $signed({b[SW-1], b});
        if (s[SW] != s[SW-1])
            return s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        return s[SW-1:0];
    endfunction

    always_comb begin
        w_sum = {sat_add(r_srd[3*SW-1:2*SW], w_n[0]),
                 sat_add(r_srd[2*SW-1:SW], w_n[1]),
                 sat_add(r_srd[SW-1:0], w_n[2])};
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && i_data.op == vna_pkg::OpLoad) begin
            r_vmem[i_data.index_a] <= {i_data.coord_x, i_data.coord_y, i_data.coord_z};
            r_smem[i_data.index_a] <= '0;
        end else if (r_state == S_UPWR) begin
            r_smem[w_uidx] <= w_sum;
        end
        if (r_state == S_RD) r_vrd <= r_vmem[w_vaddr];
        r_srd <= r_smem[w_vaddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            if (r_vld && i_ready) r_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in <= i_data;
                        r_k  <= 2'd0;
                        case (i_data.op)
                            vna_pkg::OpTri:  r_state <= S_RD;
                            vna_pkg::OpRead: r_state <= S_UPRD;
                            default:         r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RD: r_state <= S_RDW;
                S_RDW: begin
                    if (r_k == 2'd0) begin
                        r_v0[0] <= w_c[0];
                        r_v0[1] <= w_c[1];
                        r_v0[2] <= w_c[2];
                    end else if (r_k == 2'd1) begin
                        r_e1[0] <= (CWd+1)'(w_c[0]) - (CWd+1)'(r_v0[0]);
                        r_e1[1] <= (CWd+1)'(w_c[1]) - (CWd+1)'(r_v0[1]);
                        r_e1[2] <= (CWd+1)'(w_c[2]) - (CWd+1)'(r_v0[2]);
                    end else begin
                        r_e2[0] <= (CWd+1)'(w_c[0]) - (CWd+1)'(r_v0[0]);
                        r_e2[1] <= (CWd+1)'(w_c[1]) - (CWd+1)'(r_v0[1]);
                        r_e2[2] <= (CWd+1)'(w_c[2]) - (CWd+1)'(r_v0[2]);
                    end
                    if (r_k == 2'd2) r_state <= S_MUL;
                    else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_RD;
                    end
                end
                S_MUL: begin
                    r_p[0] <= XW'(r_e1[1] * r_e2[2]);
                    r_p[1] <= XW'(r_e1[2] * r_e2[1]);
                    r_p[2] <= XW'(r_e1[2] * r_e2[0]);
                    r_p[3] <= XW'(r_e1[0] * r_e2[2]);
                    r_p[4] <= XW'(r_e1[0] * r_e2[1]);
                    r_p[5] <= XW'(r_e1[1] * r_e2[0]);
                    r_state <= S_CROSS;
                end
                S_CROSS: begin
                    r_c[0]  <= r_p[0] - r_p[1];
                    r_c[1]  <= r_p[2] - r_p[3];
                    r_c[2]  <= r_p[4] - r_p[5];
                    r_start <= 1'b1;
                    r_state <= S_WAIT;
                end
                S_START: begin
                    r_c[0]  <= XW'($signed(r_srd[3*SW-1:2*SW]));
                    r_c[1]  <= XW'($signed(r_srd[2*SW-1:SW]));
                    r_c[2]  <= XW'($signed(r_srd[SW-1:0]));
                    r_start <= 1'b1;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    r_start <= 1'b0;
                    if (w_stat.done) begin
                        r_k <= 2'd0;
                        if (r_in.op == vna_pkg::OpRead) begin
                            r_res.vertex_index <= r_in.index_a;
                            r_res.normal_x <= 16'(w_n[0]);
                            r_res.normal_y <= 16'(w_n[1]);
                            r_res.normal_z <= 16'(w_n[2]);
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_UPRD;
                        end
                    end
                end
                S_UPRD: begin
                    if (r_in.op == vna_pkg::OpRead) r_state <= S_START;
                    else r_state <= S_UPWR;
                end
                S_UPWR: begin
                    if (r_k == 2'd2) r_state <= S_IDLE;
                    else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_UPRD;
                    end
                end
                S_OUT: begin
                    if (!r_vld) begin
                        r_out   <= r_res;
                        r_vld   <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = i_rst_n && (r_state == S_IDLE);
    assign o_valid = r_vld;
    assign o_data  = r_out;

    a_unit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> r_state == S_WAIT) else $error("unit done outside wait");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> !w_stat.busy) else $error("unit started while busy");
    a_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_vld) |-> $past(r_state == S_OUT)) else $error("result without read");

endmodule

>>> bench/vertex_normal_accumulator_checker.sv
// checker: watches both channels, predicts vertex normals and compares results
`timescale 1ns / 1ps
module vertex_normal_accumulator_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  vna_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  vna_pkg::t_out_beat i_out_data,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int SumMax = 524287;
    localparam int SumMin = -524288;

    logic signed [vna_pkg::CoordW-1:0] vtx_pos [vna_pkg::MaxVertices][3];
    int                                normal_sum [vna_pkg::MaxVertices][3];
    vna_pkg::t_out_beat                expected_normals [$];
    int                                err_count = 0;

    assign o_errors  = err_count;
    assign o_pending = expected_normals.size();

    function automatic longint unsigned floor_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // scale a vector to unit length in q1.14, zero vector when length is zero
    function automatic void unit_normal(input longint v [3], output int n [3]);
        longint unsigned mag [3];
        bit              neg [3];
        longint unsigned sq;
        longint unsigned len;
        longint unsigned q;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
        end
        while (mag[0] >= (64'd1 << 30) || mag[1] >= (64'd1 << 30)
                || mag[2] >= (64'd1 << 30))
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        sq = 0;
        for (int i = 0; i < 3; i++) sq = sq + mag[i] * mag[i];
        len = floor_root(sq);
        for (int i = 0; i < 3; i++) begin
            if (len == 0) begin
                n[i] = 0;
            end else begin
                q = (mag[i] * 16384 + len / 2) / len;
                n[i] = neg[i] ? -int'(q) : int'(q);
            end
        end
    endfunction

    function automatic void add_to_sum(input int idx, input int n [3]);
        int s;
        for (int i = 0; i < 3; i++) begin
            s = normal_sum[idx][i] + n[i];
            if (s > SumMax) s = SumMax;
            if (s < SumMin) s = SumMin;
            normal_sum[idx][i] = s;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch %s", $time, what);
        err_count++;
    endtask

    task automatic predict(input vna_pkg::t_in_beat b);
        longint             e1 [3];
        longint             e2 [3];
        longint             cr [3];
        longint             sv [3];
        int                 n [3];
        vna_pkg::t_out_beat r;
        case (b.op)
            vna_pkg::OpLoad: begin
                vtx_pos[b.index_a][0] = b.coord_x;
                vtx_pos[b.index_a][1] = b.coord_y;
                vtx_pos[b.index_a][2] = b.coord_z;
                for (int i = 0; i < 3; i++) normal_sum[b.index_a][i] = 0;
            end
            vna_pkg::OpTri: begin
                for (int i = 0; i < 3; i++) begin
                    e1[i] = longint'(vtx_pos[b.index_b][i]) - longint'(vtx_pos[b.index_a][i]);
                    e2[i] = longint'(vtx_pos[b.index_c][i]) - longint'(vtx_pos[b.index_a][i]);
                end
                cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                unit_normal(cr, n);
                add_to_sum(b.index_a, n);
                add_to_sum(b.index_b, n);
                add_to_sum(b.index_c, n);
            end
            vna_pkg::OpRead: begin
                for (int i = 0; i < 3; i++) sv[i] = normal_sum[b.index_a][i];
                unit_normal(sv, n);
                r.vertex_index = b.index_a;
                r.normal_x = 16'(n[0]);
                r.normal_y = 16'(n[1]);
                r.normal_z = 16'(n[2]);
                expected_normals = {expected_normals, r};
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        vna_pkg::t_out_beat want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) predict(i_in_data);
            if (i_out_valid && i_out_ready) begin
                if (expected_normals.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat for vertex %0d",
                                              i_out_data.vertex_index));
                end else begin
                    want = expected_normals.pop_front();
                    if (i_out_data.vertex_index !== want.vertex_index)
                        report_mismatch($sformatf("vertex_index: got %0d expected %0d",
                                                  i_out_data.vertex_index,
                                                  want.vertex_index));
                    if (i_out_data.normal_x !== want.normal_x)
                        report_mismatch($sformatf("normal_x: got %0d expected %0d",
                                                  i_out_data.normal_x, want.normal_x));
                    if (i_out_data.normal_y !== want.normal_y)
                        report_mismatch($sformatf("normal_y: got %0d expected %0d",
                                                  i_out_data.normal_y, want.normal_y));
                    if (i_out_data.normal_z !== want.normal_z)
                        report_mismatch($sformatf("normal_z: got %0d expected %0d",
                                                  i_out_data.normal_z, want.normal_z));
                end
            end
        end
    end

endmodule

>>> bench/vertex_normal_accumulator_core_tb.sv
// testbench top: stimulus, handshake pacing, watchdog and verdict
`timescale 1ns / 1ps
module vertex_normal_accumulator_core_tb;

    localparam int PhaseItems = 450;
    localparam int HoldCycles = 3000;
    localparam int IdleLimit  = 20000;
    localparam int IdxW       = vna_pkg::IdxW;
    localparam int CoordW     = vna_pkg::CoordW;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    vna_pkg::t_in_beat  i_data;
    logic               o_valid;
    logic               i_ready;
    vna_pkg::t_out_beat o_data;
    int                 errors;
    int                 pending;

    int        tx_idle_pct;
    int        rx_idle_pct;
    bit        hold_request;
    bit        hold_served;
    int        beats_sent;
    int        idle_cycles = 0;
    bit        is_loaded [vna_pkg::MaxVertices];
    int        loaded_list [$];

    vertex_normal_accumulator_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    vertex_normal_accumulator_checker normal_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_in_data   (i_data),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_out_data  (o_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("vertex_normal_accumulator_core_tb: errors");
                $finish;
            end
        end
    end

    // result side pacing, with one long hold-off on request
    initial begin
        i_ready     = 1'b0;
        hold_served = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                i_ready <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end else begin
                i_ready <= i_rst_n && ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic vna_pkg::t_in_beat make_beat(input logic [1:0] op, input int a,
                                                    input int b, input int c,
                                                    input int x, input int y,
                                                    input int z);
        vna_pkg::t_in_beat m;
        m.op      = op;
        m.index_a = IdxW'(a);
        m.index_b = IdxW'(b);
        m.index_c = IdxW'(c);
        m.coord_x = CoordW'(x);
        m.coord_y = CoordW'(y);
        m.coord_z = CoordW'(z);
        return m;
    endfunction

    task automatic send_beat(input vna_pkg::t_in_beat b);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic load_vertex(input int idx, input int x, input int y, input int z);
        send_beat(make_beat(vna_pkg::OpLoad, idx, $urandom_range(1023), $urandom_range(1023),
                            x, y, z));
        if (!is_loaded[idx]) begin
            is_loaded[idx] = 1'b1;
            loaded_list = {loaded_list, idx};
        end
    endtask

    task automatic add_triangle(input int a, input int b, input int c);
        send_beat(make_beat(vna_pkg::OpTri, a, b, c, $urandom, $urandom, $urandom));
    endtask

    task automatic read_normal(input int a);
        send_beat(make_beat(vna_pkg::OpRead, a, $urandom_range(1023), $urandom_range(1023),
                            $urandom, $urandom, $urandom));
    endtask

    function automatic int any_loaded();
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    function automatic int rand_coord();
        if ($urandom_range(9) < 7) return int'($urandom_range(65535));
        return int'($urandom_range(64)) - 32;
    endfunction

    task automatic random_item();
        int pick;
        int a;
        int b;
        int c;
        pick = $urandom_range(99);
        if (pick < 25) begin
            load_vertex($urandom_range(1023), rand_coord(), rand_coord(), rand_coord());
        end else if (pick < 70) begin
            add_triangle(any_loaded(), any_loaded(), any_loaded());
        end else if (pick < 90) begin
            read_normal(any_loaded());
        end else if (pick < 95) begin
            send_beat(make_beat(vna_pkg::OpRsvd, $urandom_range(1023), $urandom_range(1023),
                                $urandom_range(1023), $urandom, $urandom, $urandom));
        end else begin
            // repeated triangle pushes the corner sums toward saturation
            a = any_loaded();
            b = any_loaded();
            c = any_loaded();
            repeat ($urandom_range(20, 45)) add_triangle(a, b, c);
            read_normal(a);
            read_normal(b);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_data       = '0;
        hold_request = 1'b0;
        tx_idle_pct  = 17;
        rx_idle_pct  = 57;
        beats_sent   = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_vertex(0, 0, 0, 0);
        load_vertex(1, 32767, 0, 0);
        load_vertex(2, 0, 32767, 0);
        load_vertex(3, -32768, -32768, -32768);
        load_vertex(4, 32767, 32767, 32767);
        load_vertex(1023, -32768, 32767, -1);
        load_vertex(5, 256, 0, 0);
        read_normal(0);
        add_triangle(0, 1, 2);
        read_normal(0);
        read_normal(1);
        add_triangle(0, 2, 1);
        read_normal(0);
        add_triangle(3, 4, 1023);
        add_triangle(1, 1, 2);
        add_triangle(0, 3, 4);
        read_normal(1023);
        read_normal(3);
        send_beat(make_beat(vna_pkg::OpRsvd, 1023, 1023, 1023, -1, -1, -1));
        add_triangle(1023, 5, 0);
        read_normal(5);
        read_normal(1023);

        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                tx_idle_pct = 57;
                rx_idle_pct = 17;
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end else if (phase == 2) begin
                tx_idle_pct  = 0;
                rx_idle_pct  = 0;
                hold_request = 1'b1;
            end
            while (beats_sent < PhaseItems * (phase + 1)) random_item();
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("vertex_normal_accumulator_core_tb: clean");
        end else begin
            $display("vertex_normal_accumulator_core_tb: errors");
        end
        $finish;
    end

endmodule
